/* sv/lgs_pkg.sv */
// Shared constants, types and the B3/S23 rule for the life generation stencil.
package lgs_pkg;

  localparam int MaxWidthDefault = 128;
  localparam int WidthReset      = 80;
  localparam int HeightReset     = 60;
  localparam int HeightLimit     = 1024;

  localparam int WidthRegW  = 8;
  localparam int HeightRegW = 11;
  localparam int RowW       = 10;
  localparam int CfgDataW   = 11;

  // Configuration register indexes
  localparam logic CfgGridWidth  = 1'b0;
  localparam logic CfgGridHeight = 1'b1;

  // Window bit 3*r+c: row r (0 top), column c (0 left)
  localparam logic [8:0] MaskLeft   = 9'h049;
  localparam logic [8:0] MaskRight  = 9'h124;
  localparam logic [8:0] MaskTop    = 9'h007;
  localparam logic [8:0] MaskBottom = 9'h1C0;
  localparam logic [8:0] MaskCentre = 9'h010;

  // One column slot of the two row lines
  typedef struct packed {
    logic upper;
    logic middle;
  } lgs_pair_t;

  function automatic logic next_state(input logic [8:0] win, input logic [8:0] mask);
    logic [8:0] nb;
    logic [3:0] cnt;
    nb  = win & mask & ~MaskCentre;
    cnt = 4'd0;
    for (int i = 0; i < 9; i++) begin
      cnt = cnt + 4'(nb[i]);
    end
    if (win[4]) begin
      return (cnt == 4'd2) || (cnt == 4'd3);
    end
    return cnt == 4'd3;
  endfunction

endpackage

/* sv/lgs_cell.sv */
// One slot of the row-line chain: holds an upper and a middle row bit.
module lgs_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  logic              load_i,
  input  lgs_pkg::lgs_pair_t new_i,
  input  lgs_pkg::lgs_pair_t prev_i,
  output lgs_pkg::lgs_pair_t data_o
);
  import lgs_pkg::*;

  lgs_pair_t data_q, data_d;

  // take the fresh column at the insertion slot, else the neighbor's bits
  always_comb begin
    data_d = data_q;
    if (shift_i) begin
      data_d = load_i ? new_i : prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

/* sv/lgs_line.sv */
// Chain of cells forming the two row lines with a delay of one grid row.
module lgs_line #(
  parameter int MAX_WIDTH = lgs_pkg::MaxWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         shift_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] ins_pos_i,
  input  lgs_pkg::lgs_pair_t           new_i,
  output lgs_pkg::lgs_pair_t           tail_o
);
  import lgs_pkg::*;

  localparam int IW = $clog2(MAX_WIDTH);

  lgs_pair_t slot [MAX_WIDTH];

  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
    lgs_pair_t prev;
    if (i == 0) begin : g_head
      assign prev = '0;
    end else begin : g_body
      assign prev = slot[i-1];
    end
    lgs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift_i),
      .load_i (ins_pos_i == IW'(i)),
      .new_i  (new_i),
      .prev_i (prev),
      .data_o (slot[i])
    );
  end

  assign tail_o = slot[MAX_WIDTH-1];

endmodule

/* sv/life_generation_stencil_unit.sv */
// Top level of the life generation stencil: counters, 3x3 window and result register.
//
// Streams one generation of a Game of Life grid (rule B3/S23) in raster order.
// Input channel: alive_i/flush_i with in_valid_i and in_stall_o; a transaction
// completes when valid is high and stall is low. Output channel: next_alive_o and
// last_cell_o with out_valid_o and out_stall_i, the same handshake.
// Configuration: cfg_we_i writes grid_width (index 0, data bits 7:0) or grid_height
// (index 1); a write restarts the generation. Out-of-range values are clamped.
// The first grid_width+1 transactions of a generation give no result; from then on
// every input transaction gives one result, registered at the accepting edge. The
// sender appends grid_width+1 flush transactions after the grid; the last result
// carries last_cell_o.
// Throughput: one transaction per cycle unless the output stalls, set by the cell
// chain that shifts both row lines once per accepted transaction.
// A stalled result holds in the output register; the input is stalled only while
// that register is full and stalled.
// Reset clears the row lines, the window and the counters; the width comes up
// as 80 and the height as 60.
module life_generation_stencil_unit #(
  parameter int MAX_WIDTH = lgs_pkg::MaxWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         alive_i,
  input  logic                         flush_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         next_alive_o,
  output logic                         last_cell_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [lgs_pkg::CfgDataW-1:0] cfg_data_i
);
  import lgs_pkg::*;

  localparam int EW  = $clog2(MAX_WIDTH + 1);
  localparam int CW  = $clog2(MAX_WIDTH + 2);
  localparam int CLW = $clog2(MAX_WIDTH);
  localparam int WidthResetEff = (WidthReset > MAX_WIDTH) ? MAX_WIDTH : WidthReset;

  logic [EW-1:0]         effw_q, effw_d;
  logic [HeightRegW-1:0] effh_q, effh_d;
  logic [CW-1:0]         in_count_q, in_count_d;
  logic [CLW-1:0]        out_col_q, out_col_d;
  logic [RowW-1:0]       out_row_q, out_row_d;
  logic [8:0]            window_q, window_d;
  logic                  out_valid_q, out_valid_d;
  logic                  next_alive_q, next_alive_d;
  logic                  last_cell_q, last_cell_d;

  logic       in_fire, cur_cell, full, produce, col_last, row_last;
  logic [8:0] mask;
  logic [CLW-1:0]        ins_pos;
  logic [WidthRegW-1:0]  wr_width;
  logic [HeightRegW-1:0] wr_height;
  lgs_pair_t line_new, line_tail;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign cur_cell   = alive_i & ~flush_i;

  assign ins_pos  = CLW'(EW'(MAX_WIDTH) - effw_q);
  assign line_new = '{upper: line_tail.middle, middle: cur_cell};

  lgs_line #(.MAX_WIDTH(MAX_WIDTH)) u_line (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (in_fire),
    .ins_pos_i(ins_pos),
    .new_i    (line_new),
    .tail_o   (line_tail)
  );

  assign window_d = {cur_cell, window_q[8:7], line_tail.middle, window_q[5:4],
                     line_tail.upper, window_q[2:1]};

  assign full     = in_count_q == (CW'(effw_q) + CW'(1));
  assign produce  = in_fire & full;
  assign col_last = (EW'(out_col_q) + EW'(1)) >= effw_q;
  assign row_last = (HeightRegW'(out_row_q) + HeightRegW'(1)) >= effh_q;

  always_comb begin
    mask = 9'h1FF;
    if (out_col_q == '0) mask = mask & ~MaskLeft;
    if (col_last)        mask = mask & ~MaskRight;
    if (out_row_q == '0) mask = mask & ~MaskTop;
    if (row_last)        mask = mask & ~MaskBottom;
  end

  assign wr_width  = cfg_data_i[WidthRegW-1:0];
  assign wr_height = cfg_data_i[HeightRegW-1:0];

  always_comb begin
    effw_d       = effw_q;
    effh_d       = effh_q;
    in_count_d   = in_count_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    out_valid_d  = out_valid_q & out_stall_i;
    next_alive_d = next_alive_q;
    last_cell_d  = last_cell_q;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgGridWidth: begin
          if (wr_width == '0) begin
            effw_d = EW'(1);
          end else if (32'(wr_width) > MAX_WIDTH) begin
            effw_d = EW'(MAX_WIDTH);
          end else begin
            effw_d = EW'(wr_width);
          end
        end
        CfgGridHeight: begin
          if (wr_height == '0) begin
            effh_d = HeightRegW'(1);
          end else if (32'(wr_height) > HeightLimit) begin
            effh_d = HeightRegW'(HeightLimit);
          end else begin
            effh_d = wr_height;
          end
        end
        default: ;
      endcase
      // restart the generation
      in_count_d = '0;
      out_col_d  = '0;
      out_row_d  = '0;
    end else if (in_fire) begin
      if (!full) begin
        in_count_d = in_count_q + CW'(1);
      end else begin
        out_valid_d  = 1'b1;
        next_alive_d = next_state(window_d, mask);
        last_cell_d  = row_last & col_last;
        if (row_last && col_last) begin
          in_count_d = '0;
          out_col_d  = '0;
          out_row_d  = '0;
        end else if (col_last) begin
          out_col_d = '0;
          out_row_d = out_row_q + RowW'(1);
        end else begin
          out_col_d = out_col_q + CLW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      effw_q       <= EW'(WidthResetEff);
      effh_q       <= HeightRegW'(HeightReset);
      in_count_q   <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      window_q     <= '0;
      out_valid_q  <= 1'b0;
      next_alive_q <= 1'b0;
      last_cell_q  <= 1'b0;
    end else begin
      effw_q       <= effw_d;
      effh_q       <= effh_d;
      in_count_q   <= in_count_d;
      out_col_q    <= out_col_d;
      out_row_q    <= out_row_d;
      out_valid_q  <= out_valid_d;
      next_alive_q <= next_alive_d;
      last_cell_q  <= last_cell_d;
      if (in_fire) begin
        window_q <= window_d;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign next_alive_o = next_alive_q;
  assign last_cell_o  = last_cell_q;

  // the final cell of a generation returns every counter to the start
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (produce && row_last && col_last && !cfg_we_i) |=>
      (in_count_q == '0 && out_col_q == '0 && out_row_q == '0))
    else $error("counters not restarted after last cell");

  // output column stays inside the grid
  a_col_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EW'(out_col_q) < effw_q)
    else $error("output column beyond grid width");

  // fill count never passes the row delay
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_count_q <= (CW'(effw_q) + CW'(1)))
    else $error("fill count overran");

  // a result is shown only after an accepted transaction that produced it
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(produce))
    else $error("result without a producing transaction");

endmodule

/* test/life_generation_stencil_unit_tb.sv */
// Self-checking testbench for the life generation stencil unit, B3/S23 rule.
`timescale 1ns / 100ps

module life_generation_stencil_unit_tb;
  import lgs_pkg::*;

  // Predicts the next generation from the cells taken by the block.
  class life_scoreboard;
    typedef struct packed {
      logic next_alive;
      logic last_cell;
    } cell_result_t;

    bit [WidthRegW-1:0]       width_reg;
    bit [HeightRegW-1:0]      height_reg;
    bit [MaxWidthDefault-1:0] upper_line;
    bit [MaxWidthDefault-1:0] middle_line;
    bit [8:0]                 window;
    int unsigned              cells_taken;
    int unsigned              out_col;
    int unsigned              out_row;
    cell_result_t             due_cells[$];
    int unsigned              mismatches;
    int unsigned              results_seen;

    function new();
      width_reg    = WidthRegW'(WidthReset);
      height_reg   = HeightRegW'(HeightReset);
      upper_line   = '0;
      middle_line  = '0;
      window       = '0;
      cells_taken  = 0;
      out_col      = 0;
      out_row      = 0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MaxWidthDefault) return MaxWidthDefault;
      return 32'(width_reg);
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > HeightLimit) return HeightLimit;
      return 32'(height_reg);
    endfunction

    function int unsigned pending();
      return due_cells.size();
    endfunction

    // A write restarts the generation; the lines and the window keep their bits.
    function void write_reg(logic idx, logic [CfgDataW-1:0] data);
      if (idx == CfgGridWidth) begin
        width_reg = data[WidthRegW-1:0];
      end else begin
        height_reg = data[HeightRegW-1:0];
      end
      cells_taken = 0;
      out_col     = 0;
      out_row     = 0;
    endfunction

    function void note_cell(logic alive, logic flush);
      int unsigned  w;
      int unsigned  h;
      int unsigned  col;
      int unsigned  count;
      bit           cur;
      bit           up;
      bit           mid;
      bit           last;
      bit [8:0]     keep;
      cell_result_t res;
      w   = eff_width();
      h   = eff_height();
      cur = flush ? 1'b0 : alive;
      if (cells_taken < w) begin
        col = cells_taken;
      end else if (cells_taken == w) begin
        col = 0;
      end else begin
        col = (out_col + 1 >= w) ? 0 : out_col + 1;
      end
      col = col % MaxWidthDefault;
      up  = upper_line[col];
      mid = middle_line[col];
      upper_line[col]  = mid;
      middle_line[col] = cur;
      window = ((window >> 1) & 9'h0DB) | {6'd0, up, 2'd0} | {3'd0, mid, 5'd0} | {cur, 8'd0};
      if (cells_taken <= w) begin
        cells_taken++;
        return;
      end
      // Drop neighbors that fall outside the grid
      keep = 9'h1FF;
      if (out_col == 0) keep &= ~MaskLeft;
      if (out_col + 1 >= w) keep &= ~MaskRight;
      if (out_row == 0) keep &= ~MaskTop;
      if (out_row + 1 >= h) keep &= ~MaskBottom;
      count = $countones(window & keep & ~MaskCentre);
      res.next_alive = window[4] ? (count == 2 || count == 3) : (count == 3);
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      res.last_cell = last;
      due_cells.push_back(res);
      if (last) begin
        cells_taken = 0;
        out_col     = 0;
        out_row     = 0;
      end else if (out_col + 1 >= w) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    endfunction

    function void check_result(logic next_alive, logic last_cell);
      cell_result_t want;
      results_seen++;
      if (due_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result %0d: next_alive=%0b last_cell=%0b",
                   results_seen, next_alive, last_cell);
        end
        return;
      end
      want = due_cells.pop_front();
      if (next_alive !== want.next_alive || last_cell !== want.last_cell) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d: next_alive exp %0b got %0b, last_cell exp %0b got %0b",
                   results_seen, want.next_alive, next_alive, want.last_cell, last_cell);
        end
      end
    endfunction
  endclass

  localparam int unsigned WholeGeneration = 32'hFFFF_FFFF;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                alive_i;
  logic                flush_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                next_alive_o;
  logic                last_cell_o;
  logic                cfg_we_i;
  logic                cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  life_scoreboard board = new();
  int unsigned    cells_sent = 0;
  bit             quiet;
  bit             hold_off;

  life_generation_stencil_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .alive_i      (alive_i),
    .flush_i      (flush_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .next_alive_o (next_alive_o),
    .last_cell_o  (last_cell_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_cell(input logic alive, input logic flush);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    alive_i    <= alive;
    flush_i    <= flush;
    do @(posedge clk_i); while (in_stall_o);
    board.note_cell(alive, flush);
    cells_sent++;
  endtask

  // Send one generation: grid cells, then width+1 flush cells; stop early at cut_at.
  task automatic send_generation(input int unsigned cut_at);
    int unsigned w;
    int unsigned total;
    int unsigned density;
    int unsigned i;
    logic        alive;
    logic        flush;
    w       = board.eff_width();
    total   = w * board.eff_height() + w + 1;
    density = $urandom_range(0, 100);
    for (i = 0; i < total && i < cut_at; i++) begin
      if (i < total - w - 1) begin
        alive = ($urandom_range(0, 99) < density);
        flush = ($urandom_range(0, 49) == 0);
      end else begin
        alive = 1'($urandom_range(0, 1));
        flush = 1'b1;
      end
      send_cell(alive, flush);
    end
  endtask

  // Drop valid, drain all expected results, then let the pipeline empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
  endtask

  task automatic configure(input bit [1:0] which, input logic [CfgDataW-1:0] width_val,
                           input logic [CfgDataW-1:0] height_val);
    if (which[0]) write_reg(CfgGridWidth, width_val);
    if (which[1]) write_reg(CfgGridHeight, height_val);
    cfg_we_i <= 1'b0;
  endtask

  // Result side: check each transaction, stall at random
  initial begin
    int unsigned stall_left;
    stall_left  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && !out_stall_i) board.check_result(next_alive_o, last_cell_o);
      if (stall_left != 0) begin
        stall_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = pick_gap();
      end
      out_stall_i <= hold_off || (stall_left != 0);
    end
  end

  // Alternate between stretches with and without idling
  initial begin
    quiet <= 1'b0;
    forever begin
      repeat ($urandom_range(100, 600)) @(posedge clk_i);
      quiet <= ~quiet;
    end
  end

  // Hold off the result side so the block backs up into its input
  initial begin
    hold_off <= 1'b0;
    while (board.results_seen < 60) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk_i);
    hold_off <= 1'b0;
    while (board.results_seen < 1500) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #20000000;
    $display("life_generation_stencil_unit regression: fail");
    $finish;
  end

  initial begin
    int unsigned r;
    int unsigned gens;
    int unsigned w;
    int unsigned h;
    int unsigned i;
    logic [8:0]  blinker;
    in_valid_i  <= 1'b0;
    alive_i     <= 1'b0;
    flush_i     <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CfgGridWidth;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: first part of row 0 of an 80 x 60 grid
    repeat (WidthReset + 1 + 24) send_cell(1'($urandom_range(0, 1)), 1'b0);

    // Blinker on 3 x 3, live cells in the trailing flush transactions
    settle();
    configure(2'b11, 3, 3);
    blinker = 9'b000_111_000;
    for (i = 0; i < 9; i++) send_cell(blinker[i], 1'b0);
    repeat (4) send_cell(1'b1, 1'b1);

    // Width with high garbage bits, height zero taken as one
    settle();
    configure(2'b11, 11'h703, 0);
    repeat (3) send_cell(1'b1, 1'b0);
    repeat (4) send_cell(1'b1, 1'b1);

    // Width zero taken as one: a single cell
    settle();
    configure(2'b01, 0, 0);
    send_cell(1'b1, 1'b0);
    repeat (2) send_cell(1'b0, 1'b1);

    // Flush inside the grid kills that cell
    settle();
    configure(2'b11, 2, 2);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b1);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    repeat (3) send_cell(1'b0, 1'b1);

    // Size extremes and clamping
    settle();
    configure(2'b11, CfgDataW'(MaxWidthDefault), 2);
    send_generation(WholeGeneration);
    settle();
    configure(2'b11, 255, 1);
    send_generation(WholeGeneration);
    settle();
    configure(2'b11, 0, 2047);
    send_generation(WholeGeneration);

    while (cells_sent < 1950) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 80) begin
        w = $urandom_range(0, 8);
        h = $urandom_range(0, 8);
      end else if (r < 95) begin
        w = $urandom_range(9, 40);
        h = $urandom_range(1, 4);
      end else begin
        w = $urandom_range(129, 2047);
        h = $urandom_range(1, 2);
      end
      configure(($urandom_range(0, 9) < 7) ? 2'b11 : 2'($urandom_range(1, 2)),
                CfgDataW'(w), CfgDataW'(h));
      gens = $urandom_range(1, 3);
      repeat (gens) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          send_generation(WholeGeneration);
        end else if (r < 90) begin
          send_generation($urandom_range(1, board.eff_width() * (board.eff_height() + 1)));
        end else begin
          repeat ($urandom_range(1, 30)) begin
            send_cell(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
        end
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("life_generation_stencil_unit regression: pass");
    end else begin
      $display("life_generation_stencil_unit regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/lgs_pkg.sv
sv/lgs_cell.sv
sv/lgs_line.sv
sv/life_generation_stencil_unit.sv
test/life_generation_stencil_unit_tb.sv
